// ===== rtl/bvhl_pkg.sv =====
package bvhl_pkg;

    // link constants
    localparam logic [7:0] SYNC_BYTE      = 8'hfc;
    localparam logic [7:0] MIN_FRAME_LEN  = 8'd3;
    localparam logic [7:0] LEN_OVERHEAD   = 8'd2;

    // status codes reported by the acceptor
    localparam logic [7:0] ST_IDLING      = 8'h11;
    localparam logic [7:0] ST_ESCROW      = 8'h13;
    localparam logic [7:0] ST_VEND        = 8'h15;
    localparam logic [7:0] ST_STACKED     = 8'h16;
    localparam logic [7:0] ST_DISABLED    = 8'h1a;
    localparam logic [7:0] ST_POWERUP_LO  = 8'h40;
    localparam logic [7:0] ST_POWERUP_HI  = 8'h42;

    // escrow data codes that name a known bill
    localparam logic [7:0] BILL_CODE_LO   = 8'h61;
    localparam logic [7:0] BILL_CODE_HI   = 8'h68;

    // request command codes
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_POLL    = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        bill_credited;
        logic [15:0] bill_value;
        logic        last;
    } out_t;

    typedef enum logic [2:0] {
        FR_STATUS  = 3'd0,
        FR_ACK     = 3'd1,
        FR_RESET   = 3'd2,
        FR_STACK1  = 3'd3,
        FR_RETURN  = 3'd4,
        FR_ENABLE  = 3'd5,
        FR_DISABLE = 3'd6
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t kind;
        logic [15:0] value;
    } frame_req_t;

    // index of the final byte of each command frame
    function automatic logic [2:0] frame_last_idx(frame_kind_t kind);
        logic [2:0] idx;
        unique case (kind)
            FR_ENABLE, FR_DISABLE: idx = 3'd5;
            default:               idx = 3'd4;
        endcase
        return idx;
    endfunction

    // command frame contents
    function automatic logic [7:0] frame_byte(frame_kind_t kind, logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 3'd0) begin
            b = SYNC_BYTE;
        end else if (idx == 3'd1) begin
            b = (kind == FR_ENABLE || kind == FR_DISABLE) ? 8'h06 : 8'h05;
        end else begin
            unique case (kind)
                FR_STATUS: begin
                    unique case (idx)
                        3'd2:    b = 8'h11;
                        3'd3:    b = 8'h27;
                        default: b = 8'h56;
                    endcase
                end
                FR_ACK: begin
                    unique case (idx)
                        3'd2:    b = 8'h50;
                        3'd3:    b = 8'haa;
                        default: b = 8'h05;
                    endcase
                end
                FR_RESET: begin
                    unique case (idx)
                        3'd2:    b = 8'h40;
                        3'd3:    b = 8'h2b;
                        default: b = 8'h15;
                    endcase
                end
                FR_STACK1: begin
                    unique case (idx)
                        3'd2:    b = 8'h41;
                        3'd3:    b = 8'ha2;
                        default: b = 8'h04;
                    endcase
                end
                FR_RETURN: begin
                    unique case (idx)
                        3'd2:    b = 8'h43;
                        3'd3:    b = 8'hb0;
                        default: b = 8'h27;
                    endcase
                end
                FR_ENABLE: begin
                    unique case (idx)
                        3'd2:    b = 8'hc3;
                        3'd3:    b = 8'h00;
                        3'd4:    b = 8'h04;
                        default: b = 8'hd6;
                    endcase
                end
                default: begin
                    unique case (idx)
                        3'd2:    b = 8'hc3;
                        3'd3:    b = 8'h01;
                        3'd4:    b = 8'h8d;
                        default: b = 8'hc7;
                    endcase
                end
            endcase
        end
        return b;
    endfunction

    // denomination table, pesos
    function automatic logic [15:0] denom_value(logic [2:0] slot);
        logic [15:0] v;
        unique case (slot)
            3'd0:    v = 16'd1000;
            3'd1:    v = 16'd2000;
            3'd2:    v = 16'd5000;
            3'd3:    v = 16'd10000;
            3'd4:    v = 16'd20000;
            3'd5:    v = 16'd50000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/bvhl_deframer.sv =====
module bvhl_deframer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  bvhl_pkg::in_t      s_data,
    output logic               req_valid,
    input  logic               req_ready,
    output bvhl_pkg::frame_req_t req_data
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_LEN     = 3'b010,
        PH_PAYLOAD = 3'b100
    } rx_phase_t;

    rx_phase_t  rx_phase_reg, rx_phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [1:0] payload_count_reg, payload_count_next;
    logic [7:0] status_code_reg, status_code_next;
    logic [7:0] status_data_reg, status_data_next;
    logic       ticket_pending_reg, ticket_pending_next;
    logic       bill_held_reg, bill_held_next;
    logic [2:0] bill_slot_reg, bill_slot_next;
    logic       acceptor_enabled_reg;

    logic                 req_valid_reg;
    bvhl_pkg::frame_req_t req_reg;
    bvhl_pkg::frame_req_t req_new;
    logic                 req_load;

    logic       accept;
    logic [7:0] code_v;
    logic [7:0] data_v;
    logic [7:0] left_v;
    logic [7:0] slot_diff;

    assign s_ready   = !req_valid_reg || req_ready;
    assign accept    = s_valid && s_ready;
    assign req_valid = req_valid_reg;
    assign req_data  = req_reg;

    // payload byte view of the status fields
    assign code_v    = (payload_count_reg == 2'd0) ? s_data.rx_byte : status_code_reg;
    assign data_v    = (payload_count_reg == 2'd1) ? s_data.rx_byte : status_data_reg;
    assign left_v    = bytes_left_reg - 8'd1;
    assign slot_diff = data_v - bvhl_pkg::BILL_CODE_LO;

    // receive state and answer selection
    always_comb begin
        rx_phase_next       = rx_phase_reg;
        bytes_left_next     = bytes_left_reg;
        payload_count_next  = payload_count_reg;
        status_code_next    = status_code_reg;
        status_data_next    = status_data_reg;
        ticket_pending_next = ticket_pending_reg;
        bill_held_next      = bill_held_reg;
        bill_slot_next      = bill_slot_reg;
        req_load            = 1'b0;
        req_new.kind        = bvhl_pkg::FR_STATUS;
        req_new.value       = 16'd0;
        if (accept) begin
            if (s_data.command == bvhl_pkg::CMD_POLL) begin
                req_load = 1'b1;
            end else begin
                unique case (rx_phase_reg)
                    PH_LEN: begin
                        if (s_data.rx_byte < bvhl_pkg::MIN_FRAME_LEN) begin
                            rx_phase_next = PH_HUNT;
                        end else begin
                            bytes_left_next    = s_data.rx_byte - bvhl_pkg::LEN_OVERHEAD;
                            payload_count_next = 2'd0;
                            status_data_next   = 8'd0;
                            rx_phase_next      = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        status_code_next = code_v;
                        status_data_next = data_v;
                        if (payload_count_reg != 2'd2) begin
                            payload_count_next = payload_count_reg + 2'd1;
                        end
                        bytes_left_next = left_v;
                        if (left_v == 8'd0) begin
                            rx_phase_next = PH_HUNT;
                            req_load      = 1'b1;
                            // answer the status code
                            if (code_v == bvhl_pkg::ST_IDLING) begin
                                if (!acceptor_enabled_reg) begin
                                    req_new.kind = bvhl_pkg::FR_DISABLE;
                                end
                            end else if (code_v == bvhl_pkg::ST_ESCROW) begin
                                if (data_v >= bvhl_pkg::BILL_CODE_LO &&
                                    data_v <= bvhl_pkg::BILL_CODE_HI) begin
                                    bill_slot_next      = slot_diff[2:0];
                                    bill_held_next      = 1'b1;
                                    ticket_pending_next = 1'b1;
                                    req_new.kind        = bvhl_pkg::FR_STACK1;
                                end else begin
                                    ticket_pending_next = 1'b0;
                                    req_new.kind        = bvhl_pkg::FR_RETURN;
                                end
                            end else if (code_v == bvhl_pkg::ST_VEND) begin
                                if (ticket_pending_reg) begin
                                    req_new.kind = bvhl_pkg::FR_ACK;
                                end
                            end else if (code_v == bvhl_pkg::ST_STACKED) begin
                                if (ticket_pending_reg) begin
                                    req_new.value = bill_held_reg ?
                                        bvhl_pkg::denom_value(bill_slot_reg) : 16'd0;
                                    bill_held_next      = 1'b0;
                                    ticket_pending_next = 1'b0;
                                end
                            end else if (code_v == bvhl_pkg::ST_DISABLED) begin
                                if (acceptor_enabled_reg) begin
                                    req_new.kind = bvhl_pkg::FR_ENABLE;
                                end
                            end else if (code_v >= bvhl_pkg::ST_POWERUP_LO &&
                                         code_v <= bvhl_pkg::ST_POWERUP_HI) begin
                                req_new.kind = bvhl_pkg::FR_RESET;
                            end
                        end
                    end
                    default: begin
                        rx_phase_next = (s_data.rx_byte == bvhl_pkg::SYNC_BYTE) ?
                                        PH_LEN : PH_HUNT;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_phase_reg         <= PH_HUNT;
            bytes_left_reg       <= 8'd0;
            payload_count_reg    <= 2'd0;
            status_code_reg      <= 8'd0;
            status_data_reg      <= 8'd0;
            ticket_pending_reg   <= 1'b0;
            bill_held_reg        <= 1'b0;
            bill_slot_reg        <= 3'd0;
            acceptor_enabled_reg <= 1'b1;
            req_valid_reg        <= 1'b0;
        end else begin
            rx_phase_reg       <= rx_phase_next;
            bytes_left_reg     <= bytes_left_next;
            payload_count_reg  <= payload_count_next;
            status_code_reg    <= status_code_next;
            status_data_reg    <= status_data_next;
            ticket_pending_reg <= ticket_pending_next;
            bill_held_reg      <= bill_held_next;
            bill_slot_reg      <= bill_slot_next;
            if (cfg_wr_en) begin
                acceptor_enabled_reg <= cfg_wr_data;
            end
            if (req_load) begin
                req_valid_reg <= 1'b1;
            end else if (req_ready) begin
                req_valid_reg <= 1'b0;
            end
        end
    end

    // frame request register
    always_ff @(posedge aclk) begin
        if (req_load) begin
            req_reg <= req_new;
        end
    end

endmodule

// ===== rtl/bvhl_serializer.sv =====
module bvhl_serializer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bvhl_pkg::frame_req_t req_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bvhl_pkg::out_t       m_data
);

    logic                  busy_reg;
    bvhl_pkg::frame_kind_t kind_reg;
    logic [15:0]           value_reg;
    logic [2:0]            idx_reg;
    logic                  last_byte;
    logic                  first_byte;

    assign last_byte  = idx_reg == bvhl_pkg::frame_last_idx(kind_reg);
    assign first_byte = idx_reg == 3'd0;
    assign req_ready  = !busy_reg || (m_ready && last_byte);
    assign m_valid    = busy_reg;

    // output byte from the frame rom
    always_comb begin
        m_data.tx_byte       = bvhl_pkg::frame_byte(kind_reg, idx_reg);
        m_data.bill_credited = first_byte && (value_reg != 16'd0);
        m_data.bill_value    = first_byte ? value_reg : 16'd0;
        m_data.last          = last_byte;
    end

    // frame walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req_ready) begin
            busy_reg <= req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_ready) begin
            kind_reg  <= req_data.kind;
            value_reg <= req_data.value;
            idx_reg   <= 3'd0;
        end else if (busy_reg && m_ready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

// ===== rtl/bill_validator_host_link.sv =====
// answer path: a request that ends a frame is held in the deframer's request register,
// then in the serialiser's frame registers; throughput: one request per cycle while no
// frame request waits to be taken; each frame is 5 or 6 bytes, set by the frame serialiser
// reset: synchronous, active low; receiver hunts for sync, no bill pending, acceptor enabled
module bill_validator_host_link (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  bvhl_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bvhl_pkg::out_t m_data
);

    logic                 req_valid;
    logic                 req_ready;
    bvhl_pkg::frame_req_t req_data;

    // deframer and answer decision
    bvhl_deframer u_deframer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data)
    );

    // command frame output
    bvhl_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/bvhl_checker.sv =====
module bvhl_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input bvhl_pkg::out_t m_data
);

    // nothing leaves the block straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a credit only rides on the sync byte and carries a value
    a_credit_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bill_credited) |->
        (m_data.bill_value != 16'd0 && m_data.tx_byte == bvhl_pkg::SYNC_BYTE))
        else $error("bill credit outside frame start");

    // bill value is zero on frame body bytes
    a_value_body: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.tx_byte != bvhl_pkg::SYNC_BYTE) |->
        (m_data.bill_value == 16'd0 && !m_data.bill_credited))
        else $error("bill value on frame body byte");

    // a new frame starts with sync after the final byte
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last) |=>
        (!m_valid || m_data.tx_byte == bvhl_pkg::SYNC_BYTE))
        else $error("frame does not start with sync");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind bill_validator_host_link bvhl_checker u_bvhl_checker (.*);
